// ----- hw/rtl/hsfd_pkg.sv -----
`default_nettype none

package hsfd_pkg;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    localparam int TEMP_SPAN    = 17500;
    localparam int HUM_SPAN     = 10000;
    localparam int FULL_SCALE   = 65535;
    localparam int C_OFFSET     = 4500;
    // floor(9*C/5) + 3200 is rewritten as floor(9*(C+4500)/5) - 4900.
    localparam int F_OFFSET     = 4900;
    // floor(m/5) == (m*52429) >> 18 for every m below 2^18.
    localparam int RECIP5       = 52429;
    localparam int RECIP5_SHIFT = 18;

    localparam logic [2:0] POS_TEMP_HI = 3'd0;
    localparam logic [2:0] POS_TEMP_LO = 3'd1;
    localparam logic [2:0] POS_TEMP_CRC = 3'd2;
    localparam logic [2:0] POS_HUM_HI = 3'd3;
    localparam logic [2:0] POS_HUM_LO = 3'd4;
    localparam logic [2:0] POS_HUM_CRC = 3'd5;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } in_item_t;

    typedef struct packed {
        logic signed [14:0] temp_c_centi;
        logic signed [15:0] temp_f_centi;
        logic [13:0]        humidity_centi;
        logic               crc_error;
    } out_item_t;

    typedef struct packed {
        logic [15:0] temp_word;
        logic [15:0] hum_word;
        logic        crc_bad;
    } frame_t;

    // MSB-first CRC-8 update over one byte.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/humidity_sensor_frame_decoder_core.sv -----
`default_nettype none

// Channel  | Handshake             | Payload                  | Moves
// ---------+-----------------------+--------------------------+--------------------------
// rx       | rx_valid / rx_stall   | rx_item (in_item_t)      | one frame byte per item
// meas     | meas_valid / meas_stall | meas_item (out_item_t) | one result per full frame
//
// One byte item is taken per cycle while rx_stall is low; the frame state updates in the cycle it is taken.
// After the sixth byte the frame capture register is loaded with the finished frame, then
// three arithmetic stages (scale multiply, divide by 65535, divide by five) and the result
// register follow.
// Reset clears the byte position, the running CRC (to 0xFF), the words and all valid bits.
// A stalled result backs up the stages; rx_stall rises only once the capture register
// holds a finished frame that cannot move on.

module humidity_sensor_frame_decoder_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                rx_valid,
    output logic                     rx_stall,
    input  wire hsfd_pkg::in_item_t  rx_item,
    output logic                     meas_valid,
    input  wire logic                meas_stall,
    output hsfd_pkg::out_item_t      meas_item
);
    import hsfd_pkg::*;

    logic   frame_valid;
    logic   frame_ready;
    frame_t frame_item;

    hsfd_frame u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_valid    (rx_valid),
        .rx_stall    (rx_stall),
        .rx_item     (rx_item),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame_item  (frame_item)
    );

    hsfd_math u_math (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame_item  (frame_item),
        .meas_valid  (meas_valid),
        .meas_stall  (meas_stall),
        .meas_item   (meas_item)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/hsfd_frame.sv -----
`default_nettype none

module hsfd_frame (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rx_valid,
    output logic                   rx_stall,
    input  wire hsfd_pkg::in_item_t rx_item,
    output logic                   frame_valid,
    input  wire logic              frame_ready,
    output hsfd_pkg::frame_t       frame_item
);
    import hsfd_pkg::*;

    logic [2:0]  pos_reg, pos_next, pos_eff;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] temp_reg, temp_next;
    logic [15:0] hum_reg, hum_next;
    logic        bad_reg, bad_next;
    logic        fvalid_reg, fvalid_next;
    frame_t      fitem_reg, fitem_next;
    logic        accept;
    logic        done;

    assign rx_stall    = fvalid_reg && !frame_ready;
    assign accept      = rx_valid && !rx_stall;
    assign frame_valid = fvalid_reg;
    assign frame_item  = fitem_reg;

    always_comb
    begin
        pos_eff = (rx_item.frame_start || pos_reg > POS_HUM_CRC) ? POS_TEMP_HI : pos_reg;
        crc_next  = crc_reg;
        temp_next = temp_reg;
        hum_next  = hum_reg;
        bad_next  = bad_reg;
        pos_next  = pos_eff + 3'd1;
        done      = 1'b0;
        unique case (pos_eff)
            POS_TEMP_HI:
            begin
                crc_next  = crc8_byte(CRC_INIT, rx_item.rx_byte);
                temp_next = {rx_item.rx_byte, temp_reg[7:0]};
            end
            POS_TEMP_LO:
            begin
                crc_next  = crc8_byte(crc_reg, rx_item.rx_byte);
                temp_next = {temp_reg[15:8], rx_item.rx_byte};
            end
            POS_TEMP_CRC:
            begin
                bad_next = (crc_reg != rx_item.rx_byte);
                crc_next = CRC_INIT;
            end
            POS_HUM_HI:
            begin
                crc_next = crc8_byte(CRC_INIT, rx_item.rx_byte);
                hum_next = {rx_item.rx_byte, hum_reg[7:0]};
            end
            POS_HUM_LO:
            begin
                crc_next = crc8_byte(crc_reg, rx_item.rx_byte);
                hum_next = {hum_reg[15:8], rx_item.rx_byte};
            end
            default:
            begin
                done     = 1'b1;
                crc_next = CRC_INIT;
                pos_next = POS_TEMP_HI;
            end
        endcase

        fitem_next.temp_word = temp_reg;
        fitem_next.hum_word  = hum_reg;
        fitem_next.crc_bad   = bad_reg || (crc_reg != rx_item.rx_byte);

        if (accept && done)
        begin
            fvalid_next = 1'b1;
        end
        else if (frame_ready)
        begin
            fvalid_next = 1'b0;
        end
        else
        begin
            fvalid_next = fvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= POS_TEMP_HI;
            crc_reg    <= CRC_INIT;
            temp_reg   <= '0;
            hum_reg    <= '0;
            bad_reg    <= 1'b0;
            fvalid_reg <= 1'b0;
        end
        else
        begin
            fvalid_reg <= fvalid_next;
            if (accept)
            begin
                pos_reg  <= pos_next;
                crc_reg  <= crc_next;
                temp_reg <= temp_next;
                hum_reg  <= hum_next;
                bad_reg  <= bad_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && done)
        begin
            fitem_reg <= fitem_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/hsfd_math.sv -----
`default_nettype none

module hsfd_math (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             frame_valid,
    output logic                  frame_ready,
    input  wire hsfd_pkg::frame_t frame_item,
    output logic                  meas_valid,
    input  wire logic             meas_stall,
    output hsfd_pkg::out_item_t   meas_item
);
    import hsfd_pkg::*;

    // Stage 1: scale products.
    logic        v1_reg;
    logic [30:0] tp1_reg;
    logic [29:0] hp1_reg;
    logic        bad1_reg;
    // Stage 2: quotients by 65535 and 9*q.
    logic        v2_reg;
    logic [14:0] q2_reg;
    logic [13:0] h2_reg;
    logic [17:0] m2_reg;
    logic        bad2_reg;
    // Stage 3: division of 9*q by five.
    logic        v3_reg;
    logic [14:0] q3_reg;
    logic [13:0] h3_reg;
    logic [14:0] f3_reg;
    logic        bad3_reg;
    // Result register.
    logic        vo_reg;
    out_item_t   out_reg, out_next;

    logic        rdy1, rdy2, rdy3;
    logic [30:0] tp1_next;
    logic [29:0] hp1_next;
    logic [14:0] ta;
    logic [15:0] tb;
    logic [16:0] tsum;
    logic [13:0] ha;
    logic [15:0] hb;
    logic [16:0] hsum;
    logic [14:0] q2_next;
    logic [13:0] h2_next;
    logic [17:0] m2_next;
    logic [33:0] prod5;
    logic [15:0] c_wide, f_wide;

    assign rdy3        = !vo_reg || !meas_stall;
    assign rdy2        = !v3_reg || rdy3;
    assign rdy1        = !v2_reg || rdy2;
    assign frame_ready = !v1_reg || rdy1;
    assign meas_valid  = vo_reg;
    assign meas_item   = out_reg;

    always_comb
    begin
        tp1_next = 31'(TEMP_SPAN) * {15'b0, frame_item.temp_word};
        hp1_next = 30'(HUM_SPAN) * {14'b0, frame_item.hum_word};

        // x/65535 = a + (a+b)/65535 for x = a*65536 + b, and a+b stays below 2*65535.
        ta      = tp1_reg[30:16];
        tb      = tp1_reg[15:0];
        tsum    = {2'b0, ta} + {1'b0, tb};
        q2_next = ta + {14'b0, (tsum >= 17'(FULL_SCALE))};
        ha      = hp1_reg[29:16];
        hb      = hp1_reg[15:0];
        hsum    = {3'b0, ha} + {1'b0, hb};
        h2_next = ha + {13'b0, (hsum >= 17'(FULL_SCALE))};
        m2_next = {q2_next, 3'b0} + {3'b0, q2_next};

        prod5 = {16'b0, m2_reg} * 34'(RECIP5);

        c_wide = {1'b0, q3_reg} - 16'(C_OFFSET);
        f_wide = {1'b0, f3_reg} - 16'(F_OFFSET);
        if (bad3_reg)
        begin
            out_next.temp_c_centi   = '0;
            out_next.temp_f_centi   = '0;
            out_next.humidity_centi = '0;
            out_next.crc_error      = 1'b1;
        end
        else
        begin
            out_next.temp_c_centi   = c_wide[14:0];
            out_next.temp_f_centi   = f_wide;
            out_next.humidity_centi = h3_reg;
            out_next.crc_error      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (frame_ready)
            begin
                v1_reg <= frame_valid;
            end
            if (rdy1)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy2)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy3)
            begin
                vo_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_ready)
        begin
            tp1_reg  <= tp1_next;
            hp1_reg  <= hp1_next;
            bad1_reg <= frame_item.crc_bad;
        end
        if (rdy1)
        begin
            q2_reg   <= q2_next;
            h2_reg   <= h2_next;
            m2_reg   <= m2_next;
            bad2_reg <= bad1_reg;
        end
        if (rdy2)
        begin
            q3_reg   <= q2_reg;
            h3_reg   <= h2_reg;
            f3_reg   <= prod5[RECIP5_SHIFT+14:RECIP5_SHIFT];
            bad3_reg <= bad2_reg;
        end
        if (rdy3)
        begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/hsfd_checker.sv -----
`default_nettype none

module hsfd_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                rx_valid,
    input wire logic                rx_stall,
    input wire hsfd_pkg::in_item_t  rx_item,
    input wire logic                meas_valid,
    input wire logic                meas_stall,
    input wire hsfd_pkg::out_item_t meas_item
);
    import hsfd_pkg::*;

    logic signed [19:0] c_ext;
    logic signed [19:0] f_ext;

    assign c_ext = 20'(meas_item.temp_c_centi);
    assign f_ext = 20'(meas_item.temp_f_centi);

    // A byte item held off by the block stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        rx_valid && rx_stall |=> rx_valid && $stable(rx_item))
        else $error("stalled byte item changed");

    // A result held by the consumer stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        meas_valid && meas_stall |=> meas_valid && $stable(meas_item))
        else $error("stalled result changed");

    // A CRC failure carries zero values.
    assert property (@(posedge clk) disable iff (!rst_n)
        meas_valid && meas_item.crc_error |->
            meas_item.temp_c_centi == 15'sd0 && meas_item.temp_f_centi == 16'sd0 &&
            meas_item.humidity_centi == 14'd0)
        else $error("error result with nonzero values");

    // Celsius and humidity stay within the sensor span.
    assert property (@(posedge clk) disable iff (!rst_n)
        meas_valid && !meas_item.crc_error |->
            c_ext >= -20'sd4500 && c_ext <= 20'sd13000 &&
            meas_item.humidity_centi <= 14'd10000)
        else $error("result out of range");

    // Fahrenheit is floor(9*C/5) + 3200 of the Celsius value beside it.
    assert property (@(posedge clk) disable iff (!rst_n)
        meas_valid && !meas_item.crc_error |->
            (5 * (f_ext - 20'sd3200) <= 9 * c_ext) &&
            (9 * c_ext < 5 * (f_ext - 20'sd3200) + 20'sd5))
        else $error("Fahrenheit does not match Celsius");

endmodule

bind humidity_sensor_frame_decoder_core hsfd_checker u_hsfd_checker (.*);

`default_nettype wire

// ----- sim/humidity_sensor_frame_decoder_core_test.sv -----
`default_nettype none

module humidity_sensor_frame_decoder_core_test;

    import hsfd_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 200;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_UNTIL   = 1500;
    localparam int F_BASE         = 3200;
    localparam int F_MUL          = 9;
    localparam int F_DIV          = 5;

    logic clk;
    logic rst_n = 1'b0;
    logic rx_valid = 1'b0;
    logic rx_stall;
    in_item_t rx_item = '0;
    logic meas_valid;
    logic meas_stall = 1'b0;
    out_item_t meas_item;

    // Predictor state for the frame decoder.
    logic [2:0]  frame_pos = POS_TEMP_HI;
    logic [7:0]  crc_acc = CRC_INIT;
    logic [15:0] raw_temp = '0;
    logic [15:0] raw_hum = '0;
    logic        temp_crc_fail = 1'b0;

    out_item_t meas_expected[$];
    int mismatch_count = 0;
    int bytes_sent = 0;
    int quiet_cycles = 0;
    bit rx_idle_on = 1'b0;
    bit meas_idle_on = 1'b0;
    bit hold_request = 1'b0;
    bit hold_active = 1'b0;

    humidity_sensor_frame_decoder_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_valid   (rx_valid),
        .rx_stall   (rx_stall),
        .rx_item    (rx_item),
        .meas_valid (meas_valid),
        .meas_stall (meas_stall),
        .meas_item  (meas_item)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // CRC-8 over one byte, shifting the data in bit by bit, MSB first.
    function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] r;
        logic       fb;
        r = acc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = r[7] ^ data[i];
            r = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return r;
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 15));
            3: return 16'hFFFF - 16'($urandom_range(0, 15));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic decode_rx_byte(input logic [7:0] b, input logic fs);
        logic [2:0] pos;
        logic       frame_bad;
        int         c_val;
        int         n9;
        int         f_val;
        int         h_val;
        out_item_t  m;
        pos = (fs || frame_pos > POS_HUM_CRC) ? POS_TEMP_HI : frame_pos;
        case (pos)
            POS_TEMP_HI:
            begin
                crc_acc = crc8_step(CRC_INIT, b);
                raw_temp[15:8] = b;
            end
            POS_TEMP_LO:
            begin
                crc_acc = crc8_step(crc_acc, b);
                raw_temp[7:0] = b;
            end
            POS_TEMP_CRC:
            begin
                temp_crc_fail = (crc_acc != b);
                crc_acc = CRC_INIT;
            end
            POS_HUM_HI:
            begin
                crc_acc = crc8_step(CRC_INIT, b);
                raw_hum[15:8] = b;
            end
            POS_HUM_LO:
            begin
                crc_acc = crc8_step(crc_acc, b);
                raw_hum[7:0] = b;
            end
            default:
            begin
            end
        endcase
        if (pos != POS_HUM_CRC)
        begin
            frame_pos = pos + 3'd1;
        end
        else
        begin
            frame_bad = temp_crc_fail || (crc_acc != b);
            frame_pos = POS_TEMP_HI;
            crc_acc = CRC_INIT;
            m = '0;
            if (frame_bad)
            begin
                m.crc_error = 1'b1;
            end
            else
            begin
                c_val = (TEMP_SPAN * int'(raw_temp)) / FULL_SCALE - C_OFFSET;
                // Division truncates toward zero, so negative remainders are floored here.
                n9 = F_MUL * c_val;
                f_val = n9 / F_DIV;
                if (n9 < 0 && n9 % F_DIV != 0)
                begin
                    f_val = f_val - 1;
                end
                f_val = f_val + F_BASE;
                h_val = (HUM_SPAN * int'(raw_hum)) / FULL_SCALE;
                m.temp_c_centi = c_val[14:0];
                m.temp_f_centi = f_val[15:0];
                m.humidity_centi = h_val[13:0];
            end
            meas_expected.push_back(m);
        end
    endtask

    // Offers one item and returns at the edge where it is taken.
    task automatic send_byte(input logic [7:0] b, input logic fs);
        in_item_t item;
        item.rx_byte = b;
        item.frame_start = fs;
        if (rx_idle_on && $urandom_range(0, 3) == 0)
        begin
            rx_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_item <= item;
        @(posedge clk);
        while (rx_stall)
        begin
            @(posedge clk);
        end
        decode_rx_byte(b, fs);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [15:0] t_word, input logic [15:0] h_word,
                              input logic start, input logic bad_t, input logic bad_h);
        logic [7:0] t_crc;
        logic [7:0] h_crc;
        t_crc = crc8_step(crc8_step(CRC_INIT, t_word[15:8]), t_word[7:0]);
        h_crc = crc8_step(crc8_step(CRC_INIT, h_word[15:8]), h_word[7:0]);
        if (bad_t)
        begin
            t_crc = t_crc ^ 8'($urandom_range(1, 255));
        end
        if (bad_h)
        begin
            h_crc = h_crc ^ 8'($urandom_range(1, 255));
        end
        send_byte(t_word[15:8], start);
        send_byte(t_word[7:0], 1'b0);
        send_byte(t_crc, 1'b0);
        send_byte(h_word[15:8], 1'b0);
        send_byte(h_word[7:0], 1'b0);
        send_byte(h_crc, 1'b0);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Extremes of both words, both CRC failures, and a resync in mid frame.
    task automatic test_directed();
        send_frame(16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b0);
        send_frame(16'hFFFF, 16'h0000, 1'b1, 1'b0, 1'b0);
        send_frame(16'hBEEF, 16'h1234, 1'b1, 1'b1, 1'b0);
        send_byte(8'hA5, 1'b1);
        send_frame(16'h6666, 16'h8000, 1'b1, 1'b0, 1'b1);
    endtask

    // Mostly well-formed frames with random content, some truncated frames and noise.
    task automatic test_random_frames();
        int  kind;
        int  n;
        bit  need_start;
        need_start = 1'b0;
        rx_idle_on = 1'b1;
        meas_idle_on = 1'b1;
        while (bytes_sent < RANDOM_UNTIL)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 6)
            begin
                send_frame(pick_word(), pick_word(), need_start || $urandom_range(0, 1) == 1,
                           $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
                need_start = 1'b0;
            end
            else if (kind == 7)
            begin
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++)
                begin
                    send_byte(8'($urandom), i == 0 && $urandom_range(0, 1) == 1);
                end
                need_start = 1'b1;
            end
            else
            begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                begin
                    send_byte(8'($urandom), $urandom_range(0, 3) == 0);
                end
            end
        end
    endtask

    // The receiver holds off long enough for the block to fill and stall its input.
    task automatic test_backpressure();
        rx_idle_on = 1'b0;
        hold_request = 1'b1;
        for (int i = 0; i < 40; i++)
        begin
            send_frame(pick_word(), pick_word(), 1'b1, 1'b0, $urandom_range(0, 9) == 0);
        end
        while (hold_request || hold_active)
        begin
            @(posedge clk);
        end
    endtask

    task automatic test_full_rate();
        rx_idle_on = 1'b0;
        meas_idle_on = 1'b0;
        for (int i = 0; i < 34; i++)
        begin
            send_frame(pick_word(), pick_word(), $urandom_range(0, 1) == 1,
                       $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
        end
    endtask

    initial
    begin : meas_stall_gen
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_active = 1'b1;
                meas_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                meas_stall <= 1'b0;
                hold_active = 1'b0;
            end
            else if (meas_idle_on && $urandom_range(0, 5) == 0)
            begin
                meas_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                meas_stall <= 1'b0;
            end
        end
    end

    initial
    begin : meas_check
        out_item_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && ((rx_valid && !rx_stall) || (meas_valid && !meas_stall)))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (rst_n && meas_valid && !meas_stall)
            begin
                if (meas_expected.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %p",
                             $time, meas_item);
                    mismatch_count++;
                end
                else
                begin
                    want = meas_expected.pop_front();
                    check_field("temp_c_centi", int'(want.temp_c_centi),
                                int'(meas_item.temp_c_centi));
                    check_field("temp_f_centi", int'(want.temp_f_centi),
                                int'(meas_item.temp_f_centi));
                    check_field("humidity_centi", int'(want.humidity_centi),
                                int'(meas_item.humidity_centi));
                    check_field("crc_error", int'(want.crc_error), int'(meas_item.crc_error));
                end
            end
        end
    end

    initial
    begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
        end
        $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_frames();
        test_backpressure();
        test_full_rate();
        rx_valid <= 1'b0;
        while (meas_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
hw/rtl/hsfd_pkg.sv
hw/rtl/hsfd_frame.sv
hw/rtl/hsfd_math.sv
hw/rtl/humidity_sensor_frame_decoder_core.sv
hw/rtl/hsfd_checker.sv
sim/humidity_sensor_frame_decoder_core_test.sv
